### rtl/core/prap_pkg.sv
// ----------------------------------------------------------------------------
// prap_pkg: shared types and constants for the pivot rotation block
// Word formats, datapath widths, the CORDIC arctangent table and gain.
// ----------------------------------------------------------------------------
package prap_pkg;

    // coordinate and angle formats (Q16.16 coordinates, binary angle)
    localparam int COORD_WIDTH   = 32;
    localparam int ANGLE_WIDTH   = 32;
    localparam int CORDIC_STAGES = 24;
    localparam int GUARD_BITS    = 8;

    // difference vector after quadrant fold, exact incl. negation
    localparam int DIFF_W = COORD_WIDTH + 2;
    // cordic x/y: guard bits, sqrt(2) and cordic growth plus margin
    localparam int XW     = DIFF_W + GUARD_BITS + 2;
    // residual angle
    localparam int ZW     = ANGLE_WIDTH + 2;
    // stage index covers the whole arctangent table
    localparam int STAGE_IDX_W = 6;

    // gain constant 0.6072529350 in Q30
    localparam int GAIN_FRAC = 30;
    localparam logic [GAIN_FRAC-1:0] GAIN_Q30 = 30'd652032874;
    // gain pipeline depth
    localparam int GAIN_LAT = 4;
    // scaled gain output width
    localparam int GW = XW - GUARD_BITS + 2;
    // pivot plus scaled value before saturation
    localparam int SW = GW + 1;

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_90,
        QUAD_180,
        QUAD_270
    } quadrant_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] pivot_x;
        logic signed [COORD_WIDTH-1:0] pivot_y;
        logic signed [COORD_WIDTH-1:0] target_x;
        logic signed [COORD_WIDTH-1:0] target_y;
        logic [ANGLE_WIDTH-1:0]        turn_angle;
    } point_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] rotated_x;
        logic signed [COORD_WIDTH-1:0] rotated_y;
        logic                          overflow;
    } result_t;

    // one cordic pipeline stage: vector, residual angle and pivot
    typedef struct packed {
        logic                          valid;
        logic signed [XW-1:0]          x;
        logic signed [XW-1:0]          y;
        logic signed [ZW-1:0]          z;
        logic signed [COORD_WIDTH-1:0] px;
        logic signed [COORD_WIDTH-1:0] py;
    } cordic_t;

    // arctangent of 2^-i in turn units (2^32 per turn)
    function automatic logic [ANGLE_WIDTH-1:0] atan_turn(input logic [STAGE_IDX_W-1:0] idx);
        logic [ANGLE_WIDTH-1:0] a;
        case (idx)
            6'd0:    a = 32'h2000_0000;
            6'd1:    a = 32'h12E4_051E;
            6'd2:    a = 32'h09FB_385B;
            6'd3:    a = 32'h0511_11D4;
            6'd4:    a = 32'h028B_0D43;
            6'd5:    a = 32'h0145_D7E1;
            6'd6:    a = 32'h00A2_F61E;
            6'd7:    a = 32'h0051_7C55;
            6'd8:    a = 32'h0028_BE53;
            6'd9:    a = 32'h0014_5F2F;
            6'd10:   a = 32'h000A_2F98;
            6'd11:   a = 32'h0005_17CC;
            6'd12:   a = 32'h0002_8BE6;
            6'd13:   a = 32'h0001_45F3;
            6'd14:   a = 32'h0000_A2FA;
            6'd15:   a = 32'h0000_517D;
            6'd16:   a = 32'h0000_28BE;
            6'd17:   a = 32'h0000_145F;
            6'd18:   a = 32'h0000_0A30;
            6'd19:   a = 32'h0000_0518;
            6'd20:   a = 32'h0000_028C;
            6'd21:   a = 32'h0000_0146;
            6'd22:   a = 32'h0000_00A3;
            6'd23:   a = 32'h0000_0051;
            6'd24:   a = 32'h0000_0029;
            6'd25:   a = 32'h0000_0014;
            6'd26:   a = 32'h0000_000A;
            6'd27:   a = 32'h0000_0005;
            6'd28:   a = 32'h0000_0003;
            6'd29:   a = 32'h0000_0001;
            6'd30:   a = 32'h0000_0001;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

### rtl/core/prap_cordic_stage.sv
// ----------------------------------------------------------------------------
// prap_cordic_stage: one registered CORDIC micro-rotation
// Rotates by +/- atan(2^-idx) toward a zero residual angle.
// ----------------------------------------------------------------------------
module prap_cordic_stage
    import prap_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic [STAGE_IDX_W-1:0] idx,
    input  cordic_t                prev_stage,
    output cordic_t                this_stage
);

    cordic_t stage_reg;
    cordic_t stage_next;

    // micro-rotation, zero residual turns counterclockwise
    always_comb
    begin
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;
        logic signed [ZW-1:0] at;
        xs = prev_stage.x >>> idx;
        ys = prev_stage.y >>> idx;
        at = signed'(ZW'(atan_turn(idx)));
        stage_next = prev_stage;
        if (!prev_stage.z[ZW-1])
        begin
            stage_next.x = prev_stage.x - ys;
            stage_next.y = prev_stage.y + xs;
            stage_next.z = prev_stage.z - at;
        end
        else
        begin
            stage_next.x = prev_stage.x + ys;
            stage_next.y = prev_stage.y - xs;
            stage_next.z = prev_stage.z + at;
        end
    end

    // stage register, valid bit cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign this_stage = stage_reg;

endmodule

### rtl/core/prap_gain.sv
// ----------------------------------------------------------------------------
// prap_gain: CORDIC gain compensation for one component
// round(v * GAIN_Q30 / 2^(30+GUARD_BITS)), ties away from zero, four stages.
// ----------------------------------------------------------------------------
module prap_gain
    import prap_pkg::*;
(
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [XW-1:0] v,
    output logic signed [GW-1:0] scaled
);

    localparam int HI_W   = XW - GAIN_FRAC;
    localparam int HIP_W  = HI_W + GAIN_FRAC;
    localparam int LOP_W  = 2 * GAIN_FRAC;
    localparam int SUM_W  = HIP_W + 1;
    localparam int T_W    = SUM_W - GUARD_BITS;

    logic                    neg1_reg;
    logic [XW-1:0]           mag_reg;
    logic                    neg2_reg;
    logic [HIP_W-1:0]        hi_prod_reg;
    logic [GAIN_FRAC-1:0]    lo_part_reg;
    logic                    neg3_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic signed [GW-1:0]    scaled_reg;

    logic [XW-1:0]           mag_next;
    logic [HIP_W-1:0]        hi_prod_next;
    logic [LOP_W-1:0]        lo_prod;
    logic [SUM_W-1:0]        sum_next;
    logic [T_W-1:0]          t_mag;
    logic signed [GW-1:0]    scaled_next;

    // sign and magnitude
    assign mag_next = v[XW-1] ? XW'(-v) : XW'(v);

    // split product: high and low parts of the magnitude, split at GAIN_FRAC
    assign hi_prod_next = HIP_W'(mag_reg[XW-1:GAIN_FRAC]) * HIP_W'(GAIN_Q30);
    assign lo_prod      = LOP_W'(mag_reg[GAIN_FRAC-1:0]) * LOP_W'(GAIN_Q30);

    // recombine and add the rounding half
    assign sum_next = SUM_W'(hi_prod_reg) + SUM_W'(lo_part_reg)
                    + SUM_W'(1 << (GUARD_BITS - 1));

    // drop guard bits and restore the sign
    assign t_mag       = sum_reg[SUM_W-1:GUARD_BITS];
    assign scaled_next = neg3_reg ? -signed'(GW'(t_mag)) : signed'(GW'(t_mag));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg1_reg    <= v[XW-1];
            mag_reg     <= mag_next;
            neg2_reg    <= neg1_reg;
            hi_prod_reg <= hi_prod_next;
            lo_part_reg <= lo_prod[LOP_W-1:GAIN_FRAC];
            neg3_reg    <= neg2_reg;
            sum_reg     <= sum_next;
            scaled_reg  <= scaled_next;
        end
    end

    assign scaled = scaled_reg;

endmodule

### rtl/core/point_rotate_about_pivot.sv
// ----------------------------------------------------------------------------
// point_rotate_about_pivot: rotate a point counterclockwise about a pivot
// Quadrant fold, 24-stage CORDIC, gain compensation, pivot add, saturation.
// ----------------------------------------------------------------------------
// Usage:
//   point channel (point_valid/point_stall/point) carries pivot, target and a
//   binary angle (2^32 per turn); result channel (result_valid/result_stall/
//   result) carries the rotated point in Q16.16 and an overflow flag.
//   One result word comes out for every point word, in order.
//   The path runs through one fold stage, 24 micro-rotation stages, four gain
//   stages and one saturating output register. A new word is taken every
//   cycle while the receiver does not stall; throughput is one word per cycle,
//   set by the fully unrolled rotation pipeline.
//   When the receiver stalls while a result is waiting, the whole pipeline
//   holds and point_stall rises in the same cycle; nothing is lost or
//   repeated, and flow resumes the cycle the stall drops.
//   Reset clears all valid bits; the block is ready right after reset.
// ----------------------------------------------------------------------------
module point_rotate_about_pivot
    import prap_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    point_valid,
    output logic    point_stall,
    input  point_t  point,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam logic signed [SW-1:0] SAT_MAX = SW'((64'sd1 <<< (COORD_WIDTH - 1)) - 1);
    localparam logic signed [SW-1:0] SAT_MIN = -SAT_MAX - SW'(1);

    logic                          en;
    cordic_t                       front_reg;
    cordic_t                       front_next;
    cordic_t                       stage [CORDIC_STAGES+1];

    logic [GAIN_LAT-1:0]           gv_reg;
    logic signed [COORD_WIDTH-1:0] gpx_reg [GAIN_LAT];
    logic signed [COORD_WIDTH-1:0] gpy_reg [GAIN_LAT];
    logic signed [GW-1:0]          gx;
    logic signed [GW-1:0]          gy;

    logic                          result_valid_reg;
    result_t                       result_reg;
    result_t                       result_next;

    // pipeline moves unless a finished word is held by the receiver
    assign en          = !(result_valid_reg && result_stall);
    assign point_stall = !en;

    // front stage: difference, quadrant fold, residual angle
    always_comb
    begin
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [DIFF_W-1:0] ndx;
        logic signed [DIFF_W-1:0] ndy;
        logic signed [DIFF_W-1:0] xq;
        logic signed [DIFF_W-1:0] yq;
        logic [ANGLE_WIDTH-1:0]   biased;
        logic [ANGLE_WIDTH-1:0]   resid;
        quadrant_t                quad;
        dx     = DIFF_W'(point.target_x) - DIFF_W'(point.pivot_x);
        dy     = DIFF_W'(point.target_y) - DIFF_W'(point.pivot_y);
        ndx    = DIFF_W'(point.pivot_x) - DIFF_W'(point.target_x);
        ndy    = DIFF_W'(point.pivot_y) - DIFF_W'(point.target_y);
        biased = point.turn_angle + ANGLE_WIDTH'(1 << (ANGLE_WIDTH - 3));
        quad   = quadrant_t'(biased[ANGLE_WIDTH-1:ANGLE_WIDTH-2]);
        resid  = point.turn_angle - {biased[ANGLE_WIDTH-1:ANGLE_WIDTH-2],
                                     {(ANGLE_WIDTH-2){1'b0}}};
        case (quad)
            QUAD_0:
            begin
                xq = dx;
                yq = dy;
            end
            QUAD_90:
            begin
                xq = ndy;
                yq = dx;
            end
            QUAD_180:
            begin
                xq = ndx;
                yq = ndy;
            end
            QUAD_270:
            begin
                xq = dy;
                yq = ndx;
            end
            default:
            begin
                xq = dx;
                yq = dy;
            end
        endcase
        front_next.valid = point_valid;
        front_next.x     = XW'(xq) <<< GUARD_BITS;
        front_next.y     = XW'(yq) <<< GUARD_BITS;
        front_next.z     = ZW'(signed'(resid));
        front_next.px    = point.pivot_x;
        front_next.py    = point.pivot_y;
    end

    // front register, valid bit cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
        end
        else if (en)
        begin
            front_reg <= front_next;
        end
    end

    // micro-rotation stages
    assign stage[0] = front_reg;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        prap_cordic_stage u_stage (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .idx        (STAGE_IDX_W'(i)),
            .prev_stage (stage[i]),
            .this_stage (stage[i+1])
        );
    end

    // gain compensation, one unit per component
    prap_gain u_gain_x (
        .clk    (clk),
        .en     (en),
        .v      (stage[CORDIC_STAGES].x),
        .scaled (gx)
    );

    prap_gain u_gain_y (
        .clk    (clk),
        .en     (en),
        .v      (stage[CORDIC_STAGES].y),
        .scaled (gy)
    );

    // valid and pivot follow the gain pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gv_reg <= '0;
        end
        else if (en)
        begin
            gv_reg <= {gv_reg[GAIN_LAT-2:0], stage[CORDIC_STAGES].valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gpx_reg[0] <= stage[CORDIC_STAGES].px;
            gpy_reg[0] <= stage[CORDIC_STAGES].py;
            for (int j = 1; j < GAIN_LAT; j++)
            begin
                gpx_reg[j] <= gpx_reg[j-1];
                gpy_reg[j] <= gpy_reg[j-1];
            end
        end
    end

    // pivot add and saturation
    always_comb
    begin
        logic signed [SW-1:0] sx;
        logic signed [SW-1:0] sy;
        logic                 ovx;
        logic                 ovy;
        sx  = SW'(gpx_reg[GAIN_LAT-1]) + SW'(gx);
        sy  = SW'(gpy_reg[GAIN_LAT-1]) + SW'(gy);
        ovx = (sx > SAT_MAX) || (sx < SAT_MIN);
        ovy = (sy > SAT_MAX) || (sy < SAT_MIN);
        if (sx > SAT_MAX)
        begin
            result_next.rotated_x = COORD_WIDTH'(SAT_MAX);
        end
        else if (sx < SAT_MIN)
        begin
            result_next.rotated_x = COORD_WIDTH'(SAT_MIN);
        end
        else
        begin
            result_next.rotated_x = COORD_WIDTH'(sx);
        end
        if (sy > SAT_MAX)
        begin
            result_next.rotated_y = COORD_WIDTH'(SAT_MAX);
        end
        else if (sy < SAT_MIN)
        begin
            result_next.rotated_y = COORD_WIDTH'(SAT_MIN);
        end
        else
        begin
            result_next.rotated_y = COORD_WIDTH'(sy);
        end
        result_next.overflow = ovx || ovy;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            result_valid_reg <= gv_reg[GAIN_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // overflow only with a coordinate pinned at a range limit
    a_ovf_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.overflow |->
            result.rotated_x == COORD_WIDTH'(SAT_MAX) ||
            result.rotated_x == COORD_WIDTH'(SAT_MIN) ||
            result.rotated_y == COORD_WIDTH'(SAT_MAX) ||
            result.rotated_y == COORD_WIDTH'(SAT_MIN))
        else $error("overflow flagged without saturated coordinate");

    // folded residual angle stays within one eighth turn
    a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
        front_reg.valid |->
            front_reg.z >= -ZW'(1 << (ANGLE_WIDTH - 3)) &&
            front_reg.z <  ZW'(1 << (ANGLE_WIDTH - 3)))
        else $error("residual angle outside fold range");

    // a held pipeline keeps the last rotation stage frozen
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(stage[CORDIC_STAGES].valid) && $stable(stage[CORDIC_STAGES].x))
        else $error("rotation stage moved while pipeline held");

endmodule
